FILE: rtl/mlfd_pkg.sv
// Shared types and constants for the marker/length frame deframer.
// No dependencies.
package mlfd_pkg;

    localparam int MARKER_BYTES_DEF = 8;
    localparam int COUNT_WIDTH_DEF  = 16;
    localparam int IDX_W            = 3;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 64;

    localparam logic [15:0] MAX_FRAME_RST    = 16'd12000;
    localparam logic [63:0] START_MARKER_RST = 64'h1820_55f2_5ac0_4daa;
    localparam logic [63:0] END_MARKER_RST   = 64'h422c_d9e3_ffa0_1101;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd2;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_DROPPED = 2'd2
    } kind_t;

    typedef struct packed {
        logic [15:0] max_frame_bytes;
        logic [63:0] start_marker;
        logic [63:0] end_marker;
    } cfg_t;

    typedef struct packed {
        kind_t       out_kind;
        logic [7:0]  out_byte;
        logic        footer_ok;
        logic [31:0] frame_length;
    } result_t;

    // byte i of a marker, first received byte in the top bits
    function automatic logic [7:0] marker_byte(input logic [63:0] m, input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] pos;
        pos = IDX_W'(7) - i;
        return m[8*pos +: 8];
    endfunction

endpackage

FILE: rtl/mlfd_if.sv
// Valid/ready channel interfaces for received bytes and results.
// Depends on mlfd_pkg.
interface mlfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mlfd_res_if;
    logic               valid;
    logic               ready;
    mlfd_pkg::kind_t    out_kind;
    logic [7:0]         out_byte;
    logic               footer_ok;
    logic [31:0]        frame_length;

    modport source (output valid, output out_kind, output out_byte, output footer_ok,
                    output frame_length, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input footer_ok,
                    input frame_length, output ready);
endinterface

FILE: rtl/mlfd_cfg_regs.sv
// Configuration register file: frame length limit, start and end markers.
// Depends on mlfd_pkg.
module mlfd_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mlfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mlfd_pkg::CFG_DATA_W-1:0] cfg_data,
    output mlfd_pkg::cfg_t                  cfg
);

    mlfd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_frame_bytes <= mlfd_pkg::MAX_FRAME_RST;
            cfg_reg.start_marker    <= mlfd_pkg::START_MARKER_RST;
            cfg_reg.end_marker      <= mlfd_pkg::END_MARKER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mlfd_pkg::REG_MAX_FRAME:    cfg_reg.max_frame_bytes <= cfg_data[15:0];
                mlfd_pkg::REG_START_MARKER: cfg_reg.start_marker    <= cfg_data;
                mlfd_pkg::REG_END_MARKER:   cfg_reg.end_marker      <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/mlfd_parser.sv
// Frame parser: input byte register, phase sequencer and result register.
// Depends on mlfd_pkg.
module mlfd_parser #(
    parameter int MARKER_BYTES = mlfd_pkg::MARKER_BYTES_DEF,
    parameter int COUNT_WIDTH  = mlfd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mlfd_pkg::cfg_t      cfg,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    output logic                in_ready,
    output logic                res_valid,
    output mlfd_pkg::result_t   res,
    input  logic                res_ready
);

    typedef enum logic [2:0] {
        PH_HDR   = 3'd0,
        PH_HUNT  = 3'd1,
        PH_LEN   = 3'd2,
        PH_PAY   = 3'd3,
        PH_FOOT  = 3'd4,
        PH_LEVEL = 3'd5
    } phase_t;

    localparam int IDX_W = mlfd_pkg::IDX_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MARKER_BYTES - 1);
    localparam logic [IDX_W-1:0] IDX_LEN_LAST = IDX_W'(3);
    localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

    logic                         in_valid_reg;
    logic [7:0]                   in_byte_reg;
    logic                         res_valid_reg;
    mlfd_pkg::result_t            res_reg;
    phase_t                       phase_reg, phase_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic                         hdr_mis_reg, hdr_mis_next;
    logic [31:0]                  len_reg, len_next;
    logic [COUNT_WIDTH-1:0]       cnt_reg, cnt_next;
    logic                         foot_mis_reg, foot_mis_next;
    logic                         res_fire;
    mlfd_pkg::result_t            res_next;
    logic                         advance;

    logic [7:0]                   start_b, end_b;
    logic [31:0]                  len_asm;
    logic [COUNT_WIDTH-1:0]       cnt_inc;
    logic                         oversize;

    assign advance  = in_valid_reg && (!res_valid_reg || res_ready);
    assign in_ready = !in_valid_reg || advance;

    assign start_b = mlfd_pkg::marker_byte(cfg.start_marker, idx_reg);
    assign end_b   = mlfd_pkg::marker_byte(cfg.end_marker, idx_reg);
    assign cnt_inc = cnt_reg + COUNT_WIDTH'(1);

    always_comb
    begin
        case (idx_reg[1:0])
            2'd0:    len_asm = {24'd0, in_byte_reg};
            2'd1:    len_asm = len_reg | {16'd0, in_byte_reg, 8'd0};
            2'd2:    len_asm = len_reg | {8'd0, in_byte_reg, 16'd0};
            default: len_asm = len_reg | {in_byte_reg, 24'd0};
        endcase
        oversize = (len_asm > {16'd0, cfg.max_frame_bytes}) || ({1'b0, len_asm} > COUNT_MAX);
    end

    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        hdr_mis_next  = hdr_mis_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        foot_mis_next = foot_mis_reg;
        res_fire      = 1'b0;
        res_next.out_kind     = mlfd_pkg::KIND_PAYLOAD;
        res_next.out_byte     = in_byte_reg;
        res_next.footer_ok    = 1'b0;
        res_next.frame_length = len_reg;

        case (phase_reg)
            PH_HDR:
            begin
                idx_next = idx_reg + 1'b1;
                if (in_byte_reg != start_b)
                    hdr_mis_next = 1'b1;
                if (idx_reg == IDX_LAST)
                begin
                    phase_next   = (hdr_mis_reg || in_byte_reg != start_b) ? PH_HUNT : PH_LEN;
                    idx_next     = '0;
                    hdr_mis_next = 1'b0;
                end
            end
            PH_HUNT:
            begin
                if (in_byte_reg == start_b)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == IDX_LAST)
                    begin
                        phase_next = PH_LEN;
                        idx_next   = '0;
                    end
                end
                else
                    idx_next = '0;
            end
            PH_LEN:
            begin
                len_next = len_asm;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_LEN_LAST)
                begin
                    idx_next = '0;
                    if (oversize)
                    begin
                        res_fire              = 1'b1;
                        res_next.out_kind     = mlfd_pkg::KIND_DROPPED;
                        res_next.out_byte     = 8'd0;
                        res_next.frame_length = len_asm;
                        phase_next            = PH_HDR;
                        hdr_mis_next          = 1'b0;
                        cnt_next              = '0;
                        foot_mis_next         = 1'b0;
                    end
                    else
                    begin
                        cnt_next      = '0;
                        foot_mis_next = 1'b0;
                        phase_next    = (len_asm == 32'd0) ? PH_FOOT : PH_PAY;
                    end
                end
            end
            PH_PAY:
            begin
                res_fire = 1'b1;
                cnt_next = cnt_inc;
                if (32'(cnt_inc) >= len_reg)
                begin
                    phase_next = PH_FOOT;
                    idx_next   = '0;
                end
            end
            PH_FOOT:
            begin
                idx_next = idx_reg + 1'b1;
                if (in_byte_reg != end_b)
                    foot_mis_next = 1'b1;
                if (idx_reg == IDX_LAST)
                begin
                    phase_next = PH_LEVEL;
                    idx_next   = '0;
                end
            end
            PH_LEVEL:
            begin
                res_fire           = 1'b1;
                res_next.out_kind  = mlfd_pkg::KIND_DONE;
                res_next.footer_ok = !foot_mis_reg;
                phase_next         = PH_HDR;
                idx_next           = '0;
                hdr_mis_next       = 1'b0;
                cnt_next           = '0;
                foot_mis_next      = 1'b0;
            end
            default:
            begin
                phase_next    = PH_HDR;
                idx_next      = '0;
                hdr_mis_next  = 1'b0;
                cnt_next      = '0;
                foot_mis_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_HDR;
            idx_reg       <= '0;
            hdr_mis_reg   <= 1'b0;
            len_reg       <= '0;
            cnt_reg       <= '0;
            foot_mis_reg  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                res_valid_reg <= res_fire;
                phase_reg     <= phase_next;
                idx_reg       <= idx_next;
                hdr_mis_reg   <= hdr_mis_next;
                len_reg       <= len_next;
                cnt_reg       <= cnt_next;
                foot_mis_reg  <= foot_mis_next;
            end
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= in_byte;
        if (advance && res_fire)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: rtl/marker_length_frame_deframer.sv
// Marker/length frame deframer, top level.
// Depends on mlfd_pkg, mlfd_if, mlfd_cfg_regs, mlfd_parser.
//
// Usage:
//   rx carries one received byte per transfer. A frame is a start marker,
//   a 32-bit little-endian length, the payload, an end marker and a level
//   byte. res carries one result per payload byte (kind payload), one per
//   completed frame (kind done, level byte and footer_ok) and one per
//   frame whose length exceeds the limit (kind dropped).
//   Throughput: one byte per cycle while res is not stalled, set by the
//   parser step between the input byte register and the result register.
//   A stalled res holds the result register; rx keeps taking one byte into
//   the input register, then ready drops until res drains.
//   Reset empties both registers, returns the parser to header compare and
//   loads the default limit and markers. Write configuration through
//   cfg_we/cfg_index/cfg_data only while no frame traffic is in flight.
module marker_length_frame_deframer #(
    parameter int MARKER_BYTES = mlfd_pkg::MARKER_BYTES_DEF,
    parameter int COUNT_WIDTH  = mlfd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mlfd_rx_if.sink                         rx,
    mlfd_res_if.source                      res,
    input  logic                            cfg_we,
    input  logic [mlfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mlfd_pkg::CFG_DATA_W-1:0] cfg_data
);

    mlfd_pkg::cfg_t    cfg;
    mlfd_pkg::result_t result;
    logic              ready;
    logic              res_valid;

    mlfd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mlfd_parser #(
        .MARKER_BYTES (MARKER_BYTES),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (rx.valid),
        .in_byte   (rx.rx_byte),
        .in_ready  (ready),
        .res_valid (res_valid),
        .res       (result),
        .res_ready (res.ready)
    );

    assign rx.ready         = ready;
    assign res.valid        = res_valid;
    assign res.out_kind     = result.out_kind;
    assign res.out_byte     = result.out_byte;
    assign res.footer_ok    = result.footer_ok;
    assign res.frame_length = result.frame_length;

endmodule

FILE: tb/marker_length_frame_deframer_tb.sv
// Self-checking testbench for marker_length_frame_deframer: a byte-level deframer
// predictor, directed frame tests, then randomized framed traffic with idling and stalls.
// Depends on mlfd_pkg, mlfd_if and the deframer RTL.
module marker_length_frame_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        P_HEADER, P_HUNT, P_LENGTH, P_PAYLOAD, P_FOOTER, P_LEVEL
    } parse_phase_t;

    localparam logic [31:0] COUNT_LIMIT = 32'((64'd1 << mlfd_pkg::COUNT_WIDTH_DEF) - 1);

    logic clk = 1'b0;
    logic rst_n;
    logic                            cfg_we;
    logic [mlfd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mlfd_pkg::CFG_DATA_W-1:0] cfg_data;

    mlfd_rx_if  rx_ch ();
    mlfd_res_if res_ch ();

    marker_length_frame_deframer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // deframer shadow state and settings
    logic [15:0]                          max_len;
    logic [63:0]                          start_mk;
    logic [63:0]                          end_mk;
    parse_phase_t                         phase;
    logic [3:0]                           mk_idx;
    logic                                 hdr_bad;
    logic [31:0]                          len_field;
    logic [mlfd_pkg::COUNT_WIDTH_DEF-1:0] pay_cnt;
    logic                                 foot_bad;

    mlfd_pkg::result_t pending_results[$];

    int unsigned bytes_sent;
    int unsigned burst_left;
    int unsigned mismatches;
    int unsigned payload_seen;
    int unsigned frames_done;
    int unsigned frames_dropped;
    int unsigned hunts;
    int unsigned reg_writes;
    int unsigned rcv_cycle;

    function automatic logic [7:0] marker_at(input logic [63:0] m, input int i);
        return m[63 - 8 * (i % 8) -: 8];
    endfunction

    function automatic void restart_header();
        phase    = P_HEADER;
        mk_idx   = '0;
        hdr_bad  = 1'b0;
        pay_cnt  = '0;
        foot_bad = 1'b0;
    endfunction

    function automatic bit deframe_step(input logic [7:0] b, output mlfd_pkg::result_t r);
        logic [1:0] k;
        r = '0;
        case (phase)
            P_HEADER:
            begin
                if (b != marker_at(start_mk, mk_idx)) hdr_bad = 1'b1;
                mk_idx = mk_idx + 1'b1;
                if (mk_idx >= 8)
                begin
                    if (hdr_bad) hunts++;
                    phase   = hdr_bad ? P_HUNT : P_LENGTH;
                    mk_idx  = '0;
                    hdr_bad = 1'b0;
                end
                return 1'b0;
            end
            P_HUNT:
            begin
                if (b == marker_at(start_mk, mk_idx))
                begin
                    mk_idx = mk_idx + 1'b1;
                    if (mk_idx >= 8)
                    begin
                        phase  = P_LENGTH;
                        mk_idx = '0;
                    end
                end
                else
                begin
                    mk_idx = '0;
                end
                return 1'b0;
            end
            P_LENGTH:
            begin
                k = mk_idx[1:0];
                if (k == 0) len_field = '0;
                len_field[8 * k +: 8] = b;
                mk_idx = mk_idx + 1'b1;
                if (mk_idx < 4) return 1'b0;
                mk_idx = '0;
                if (len_field > {16'd0, max_len} || len_field > COUNT_LIMIT)
                begin
                    r.out_kind     = mlfd_pkg::KIND_DROPPED;
                    r.frame_length = len_field;
                    restart_header();
                    return 1'b1;
                end
                pay_cnt  = '0;
                foot_bad = 1'b0;
                phase    = (len_field == 0) ? P_FOOTER : P_PAYLOAD;
                return 1'b0;
            end
            P_PAYLOAD:
            begin
                r.out_kind     = mlfd_pkg::KIND_PAYLOAD;
                r.out_byte     = b;
                r.frame_length = len_field;
                pay_cnt = pay_cnt + 1'b1;
                if (32'(pay_cnt) >= len_field)
                begin
                    phase  = P_FOOTER;
                    mk_idx = '0;
                end
                return 1'b1;
            end
            P_FOOTER:
            begin
                if (b != marker_at(end_mk, mk_idx)) foot_bad = 1'b1;
                mk_idx = mk_idx + 1'b1;
                if (mk_idx >= 8)
                begin
                    phase  = P_LEVEL;
                    mk_idx = '0;
                end
                return 1'b0;
            end
            P_LEVEL:
            begin
                r.out_kind     = mlfd_pkg::KIND_DONE;
                r.out_byte     = b;
                r.footer_ok    = ~foot_bad;
                r.frame_length = len_field;
                restart_header();
                return 1'b1;
            end
            default:
            begin
                restart_header();
                return 1'b0;
            end
        endcase
    endfunction

    // one byte transfer on rx; sender runs in random bursts with random gaps
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        mlfd_pkg::result_t r;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (!rx_ch.ready);
        bytes_sent++;
        if (deframe_step(b, r)) pending_results.push_back(r);
    endtask

    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mlfd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        reg_writes++;
        case (idx)
            mlfd_pkg::REG_MAX_FRAME:    max_len  = data[15:0];
            mlfd_pkg::REG_START_MARKER: start_mk = data;
            mlfd_pkg::REG_END_MARKER:   end_mk   = data;
            default: ;
        endcase
    endtask

    task automatic send_marker(input logic [63:0] m, input int n);
        for (int i = 0; i < n; i++) send_byte(marker_at(m, i));
    endtask

    task automatic send_length(input logic [31:0] len);
        for (int i = 0; i < 4; i++) send_byte(len[8 * i +: 8]);
    endtask

    // full frame; stops early when the length is refused or the header never locked
    task automatic send_frame(input logic [31:0] len, input bit bad_footer,
                              input logic [7:0] level);
        int bad_pos;
        int guard;
        send_marker(start_mk, 8);
        send_length(len);
        if (phase != P_PAYLOAD && phase != P_FOOTER) return;
        guard = 0;
        while (phase == P_PAYLOAD && guard < 64)
        begin
            send_byte(8'($urandom));
            guard++;
        end
        if (phase != P_FOOTER) return;
        bad_pos = bad_footer ? $urandom_range(0, 7) : 8;
        for (int i = 0; i < 8; i++)
            send_byte(marker_at(end_mk, i) ^ ((i == bad_pos) ? 8'($urandom_range(1, 255))
                                                             : 8'h00));
        send_byte(level);
    endtask

    // bring the parser back to a point where a clean frame locks
    task automatic resync();
        int n;
        n = 0;
        while (!(phase == P_HEADER && mk_idx == 0) && phase != P_HUNT && n < 40)
        begin
            send_byte(8'($urandom));
            n++;
        end
        if (phase == P_HUNT && mk_idx != 0)
            send_byte(marker_at(start_mk, mk_idx) ^ 8'($urandom_range(1, 255)));
    endtask

    task automatic test_basic_frames();
        send_marker(start_mk, 8);
        send_length(32'd2);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_marker(end_mk, 8);
        send_byte(8'hFF);
        send_frame(32'd0, 1'b1, 8'h00);
        send_frame(32'd1, 1'b0, 8'h80);
    endtask

    task automatic test_oversize_length();
        send_frame({16'd0, max_len} + 32'd1, 1'b0, 8'h11);
        send_frame(32'hFFFF_FFFF, 1'b0, 8'h22);
    endtask

    // broken partial match: the breaking byte equals the first marker byte
    task automatic test_hunt_restart();
        send_marker(start_mk ^ 64'h0100_0000_0000_0000, 8);
        send_byte(marker_at(start_mk, 0));
        send_byte(marker_at(start_mk, 1));
        send_byte(marker_at(start_mk, 0));
        for (int i = 1; i < 8; i++) send_byte(marker_at(start_mk, i));
        send_frame(32'd1, 1'b0, 8'h5A);
    endtask

    task automatic test_length_limit();
        wait_idle();
        write_reg(mlfd_pkg::REG_MAX_FRAME, {48'($urandom) << 16, 16'd3});
        send_frame(32'd3, 1'b0, 8'h33);
        send_frame(32'd4, 1'b0, 8'h44);
        wait_idle();
        write_reg(mlfd_pkg::REG_MAX_FRAME, 64'd0);
        send_frame(32'd0, 1'b0, 8'h01);
        send_frame(32'd1, 1'b0, 8'h02);
    endtask

    task automatic run_traffic_phase(input logic [15:0] lim, input logic [63:0] smk,
                                     input logic [63:0] emk, input int unsigned nbytes);
        int unsigned first;
        int unsigned sel;
        logic [31:0] len;
        wait_idle();
        write_reg(mlfd_pkg::REG_MAX_FRAME, {48'($urandom), lim});
        write_reg(mlfd_pkg::REG_START_MARKER, smk);
        write_reg(mlfd_pkg::REG_END_MARKER, emk);
        first = bytes_sent;
        while (bytes_sent - first < nbytes)
        begin
            sel = $urandom_range(0, 9);
            if (sel <= 6)
            begin
                case ($urandom_range(0, 3))
                    0: len = $urandom_range(0, (max_len < 12) ? max_len : 12);
                    1: len = (max_len <= 16) ? {16'd0, max_len} : $urandom_range(0, 6);
                    2: len = {16'd0, max_len} + 32'd1;
                    default: len = $urandom;
                endcase
                if (len <= {16'd0, max_len} && len > 40) len = len | 32'h8000_0000;
                send_frame(len, $urandom_range(0, 3) == 0, 8'($urandom));
            end
            else if (sel == 7)
            begin
                repeat ($urandom_range(1, 10)) send_byte(8'($urandom));
            end
            else if (sel == 8)
            begin
                send_marker(start_mk, $urandom_range(1, 7));
                send_byte(8'($urandom));
            end
            else
            begin
                send_frame(32'h0001_0000 | $urandom, 1'b0, 8'($urandom));
            end
            resync();
        end
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(16'd0, 64'd0, '1, 50);
        run_traffic_phase(16'hFFFF, '1, 64'd0, 50);
        run_traffic_phase(16'($urandom_range(1, 16)), {$urandom, $urandom},
                          {$urandom, $urandom}, 70);
        run_traffic_phase(16'($urandom_range(1, 8)), {4{16'($urandom)}},
                          {$urandom, $urandom}, 70);
        run_traffic_phase(mlfd_pkg::MAX_FRAME_RST, mlfd_pkg::START_MARKER_RST,
                          mlfd_pkg::END_MARKER_RST, 60);
    endtask

    task automatic check_result();
        mlfd_pkg::result_t exp_r;
        mlfd_pkg::result_t act_r;
        act_r.out_kind     = res_ch.out_kind;
        act_r.out_byte     = res_ch.out_byte;
        act_r.footer_ok    = res_ch.footer_ok;
        act_r.frame_length = res_ch.frame_length;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result kind %0d byte %02h ok %0b len %0d", $realtime,
                         act_r.out_kind, act_r.out_byte, act_r.footer_ok, act_r.frame_length);
            return;
        end
        exp_r = pending_results.pop_front();
        case (exp_r.out_kind)
            mlfd_pkg::KIND_PAYLOAD: payload_seen++;
            mlfd_pkg::KIND_DONE:    frames_done++;
            default:                frames_dropped++;
        endcase
        if (act_r.out_kind !== exp_r.out_kind || act_r.out_byte !== exp_r.out_byte ||
            act_r.footer_ok !== exp_r.footer_ok ||
            act_r.frame_length !== exp_r.frame_length)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"%0t: mismatch exp kind %0d byte %02h ok %0b len %0d, ",
                          "got kind %0d byte %02h ok %0b len %0d"},
                         $realtime, exp_r.out_kind, exp_r.out_byte, exp_r.footer_ok,
                         exp_r.frame_length, act_r.out_kind, act_r.out_byte,
                         act_r.footer_ok, act_r.frame_length);
        end
    endtask

    // result side: checks each transfer, stalls on a rotating pattern
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (res_ch.valid && res_ch.ready) check_result();
            rcv_cycle++;
            case (rcv_cycle[7:6])
                2'd0: res_ch.ready <= 1'b1;
                2'd1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                2'd2: res_ch.ready <= (rcv_cycle[2:0] >= 3'd5);
                default: res_ch.ready <= (rcv_cycle[3:0] == 4'd0);
            endcase
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        res_ch.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = mlfd_pkg::REG_MAX_FRAME;
        cfg_data      = '0;
        max_len       = mlfd_pkg::MAX_FRAME_RST;
        start_mk      = mlfd_pkg::START_MARKER_RST;
        end_mk        = mlfd_pkg::END_MARKER_RST;
        len_field     = '0;
        restart_header();
        bytes_sent = 0;
        burst_left = 0;
        mismatches = 0;
        payload_seen = 0;
        frames_done = 0;
        frames_dropped = 0;
        hunts = 0;
        reg_writes = 0;
        rcv_cycle = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_frames();
        test_oversize_length();
        test_hunt_restart();
        test_length_limit();
        test_random_traffic();

        wait_idle();
        repeat (10) @(posedge clk);
        $display("Sent %0d bytes: %0d payload results, %0d frames completed, %0d dropped",
                 bytes_sent, payload_seen, frames_done, frames_dropped);
        $display("%0d register writes, %0d header hunts, %0d mismatches",
                 reg_writes, hunts, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/mlfd_pkg.sv
rtl/mlfd_if.sv
rtl/mlfd_cfg_regs.sv
rtl/mlfd_parser.sv
rtl/marker_length_frame_deframer.sv
tb/marker_length_frame_deframer_tb.sv
